// ===== rtl/ffpc_pkg.sv =====
// Package with shared constants and codes for the flat-field pixel correction block.
package ffpc_pkg;

  // Frame geometry and gain format.
  localparam int unsigned FramePixels  = 65536;
  localparam int unsigned IdxW         = $clog2(FramePixels);
  localparam int unsigned GainFracBits = 4;
  localparam int unsigned PixW         = 16;
  localparam int unsigned GainW        = 20;
  localparam int unsigned ProdW        = PixW + GainW;

  // Operation codes of an input item.
  localparam logic [1:0] OpLoadDark = 2'd0;
  localparam logic [1:0] OpLoadFlat = 2'd1;
  localparam logic [1:0] OpCorrect  = 2'd2;

  // Result status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StLow     = 2'd1;
  localparam logic [1:0] StHigh    = 2'd2;
  localparam logic [1:0] StBadFlat = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegGainFull = 2'd0;
  localparam logic [1:0] RegGainBin2 = 2'd1;
  localparam logic [1:0] RegGainBin4 = 2'd2;
  localparam logic [1:0] RegBinning  = 2'd3;

  // Binning levels.
  localparam logic [1:0] BinFull = 2'd0;
  localparam logic [1:0] BinTwo  = 2'd1;

endpackage

// ===== rtl/flat_field_pixel_correction_top.sv =====
// Top level of the flat-field and dark-frame pixel correction pipeline.
//
//  channel   ports                                              direction
//  command   start, busy, operation_i, pixel_index_i,
//            pixel_value_i                                      in (busy out)
//  result    result_valid_o, corrected_value_o, status_o        out
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i                   in
//
// One item is taken every cycle; busy stays low.
// A correct item passes through the frame store read, dark subtraction, the
// gain multiply, the divider setup and sixteen restoring divider stages,
// then the output register, before its result appears. Load items write
// their frame store at the accepting edge.
// Reset clears the pipeline valid bits and the configuration registers; the
// frame stores are not cleared. The receiver cannot stall the result strobe.
module flat_field_pixel_correction_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] pixel_index_i,
  input  logic [15:0] pixel_value_i,
  output logic        result_valid_o,
  output logic [15:0] corrected_value_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);

  localparam int unsigned IdxW  = ffpc_pkg::IdxW;
  localparam int unsigned PixW  = ffpc_pkg::PixW;
  localparam int unsigned GainW = ffpc_pkg::GainW;
  localparam int unsigned ProdW = ffpc_pkg::ProdW;
  localparam int unsigned NumLo = ProdW - ffpc_pkg::GainFracBits - PixW;

  // Configuration registers.
  logic [GainW-1:0] gain_full_q, gain_bin2_q, gain_bin4_q;
  logic [1:0]       binning_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_full_q <= '0;
      gain_bin2_q <= '0;
      gain_bin4_q <= '0;
      binning_q   <= ffpc_pkg::BinFull;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffpc_pkg::RegGainFull: gain_full_q <= cfg_wdata_i;
        ffpc_pkg::RegGainBin2: gain_bin2_q <= cfg_wdata_i;
        ffpc_pkg::RegGainBin4: gain_bin4_q <= cfg_wdata_i;
        ffpc_pkg::RegBinning:  binning_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Gain chosen by binning level; level three falls back to the by-four gain.
  logic [GainW-1:0] gain_sel;
  always_comb begin
    case (binning_q)
      ffpc_pkg::BinFull: gain_sel = gain_full_q;
      ffpc_pkg::BinTwo:  gain_sel = gain_bin2_q;
      default:           gain_sel = gain_bin4_q;
    endcase
  end

  assign busy = 1'b0;

  logic accept;
  logic [IdxW-1:0] idx;
  assign accept = start && !busy;
  assign idx    = pixel_index_i[IdxW-1:0];

  // Frame stores: one write and one read per cycle each, read data registered.
  logic [PixW-1:0] dark_mem [ffpc_pkg::FramePixels];
  logic [PixW-1:0] flat_mem [ffpc_pkg::FramePixels];
  logic [PixW-1:0] dark_rd_q, flat_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == ffpc_pkg::OpLoadDark) begin
      dark_mem[idx] <= pixel_value_i;
    end
    dark_rd_q <= dark_mem[idx];
  end

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == ffpc_pkg::OpLoadFlat) begin
      flat_mem[idx] <= pixel_value_i;
    end
    flat_rd_q <= flat_mem[idx];
  end

  // Read stage: raw sample and gain travel beside the store read.
  logic             s0_v_q;
  logic [PixW-1:0]  s0_val_q;
  logic [GainW-1:0] s0_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept && operation_i == ffpc_pkg::OpCorrect;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_val_q  <= pixel_value_i;
    s0_gain_q <= gain_sel;
  end

  // Subtract stage: magnitude of raw minus dark and the flat span.
  logic             s1_v_q, s1_bad_q, s1_neg_q;
  logic [PixW-1:0]  s1_mag_q, s1_den_q;
  logic [GainW-1:0] s1_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bad_q  <= flat_rd_q <= dark_rd_q;
    s1_neg_q  <= s0_val_q < dark_rd_q;
    s1_mag_q  <= (s0_val_q < dark_rd_q) ? dark_rd_q - s0_val_q : s0_val_q - dark_rd_q;
    s1_den_q  <= flat_rd_q - dark_rd_q;
    s1_gain_q <= s0_gain_q;
  end

  // Multiply stage.
  logic             s2_v_q, s2_bad_q, s2_neg_q;
  logic [PixW-1:0]  s2_den_q;
  logic [ProdW-1:0] s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_bad_q  <= s1_bad_q;
    s2_neg_q  <= s1_neg_q;
    s2_den_q  <= s1_den_q;
    s2_prod_q <= ProdW'(s1_mag_q) * ProdW'(s1_gain_q);
  end

  // Divider: the fraction bits are dropped first, so the dividend is the
  // product shifted right; a quotient of 17 bits or more is an overflow.
  logic            dv_v_q   [NumLo+1];
  logic            dv_bad_q [NumLo+1];
  logic            dv_neg_q [NumLo+1];
  logic            dv_ovf_q [NumLo+1];
  logic [PixW-1:0] dv_den_q [NumLo+1];
  logic [PixW-1:0] dv_rem_q [NumLo+1];
  logic [NumLo-1:0] dv_num_q [NumLo+1];
  logic [PixW-1:0] dv_quo_q [NumLo+1];

  logic [PixW-1:0] top_part;
  assign top_part = s2_prod_q[ProdW-1 -: PixW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_bad_q[0] <= s2_bad_q;
    dv_neg_q[0] <= s2_neg_q;
    dv_ovf_q[0] <= top_part >= s2_den_q;
    dv_den_q[0] <= s2_den_q;
    dv_rem_q[0] <= top_part;
    dv_num_q[0] <= s2_prod_q[ProdW-PixW-1 -: NumLo];
    dv_quo_q[0] <= '0;
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= NumLo; k++) begin : g_div
    logic [PixW:0]   trial;
    logic            take;
    assign trial = {dv_rem_q[k-1], dv_num_q[k-1][NumLo-1]};
    assign take  = trial >= {1'b0, dv_den_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_bad_q[k] <= dv_bad_q[k-1];
      dv_neg_q[k] <= dv_neg_q[k-1];
      dv_ovf_q[k] <= dv_ovf_q[k-1];
      dv_den_q[k] <= dv_den_q[k-1];
      dv_rem_q[k] <= take ? PixW'(trial - {1'b0, dv_den_q[k-1]}) : trial[PixW-1:0];
      dv_num_q[k] <= {dv_num_q[k-1][NumLo-2:0], 1'b0};
      dv_quo_q[k] <= {dv_quo_q[k-1][PixW-2:0], take};
    end
  end

  // Saturation and status, then the output register.
  logic [PixW-1:0] res_val;
  logic [1:0]      res_st;
  always_comb begin
    if (dv_bad_q[NumLo]) begin
      res_val = '0;
      res_st  = ffpc_pkg::StBadFlat;
    end else if (dv_neg_q[NumLo]) begin
      res_val = '0;
      res_st  = (dv_ovf_q[NumLo] || dv_quo_q[NumLo] != '0) ? ffpc_pkg::StLow
                                                           : ffpc_pkg::StOk;
    end else if (dv_ovf_q[NumLo]) begin
      res_val = '1;
      res_st  = ffpc_pkg::StHigh;
    end else begin
      res_val = dv_quo_q[NumLo];
      res_st  = ffpc_pkg::StOk;
    end
  end

  logic            out_v_q;
  logic [PixW-1:0] out_val_q;
  logic [1:0]      out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_v_q[NumLo];
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= res_val;
    out_st_q  <= res_st;
  end

  assign result_valid_o    = out_v_q;
  assign corrected_value_o = out_val_q;
  assign status_o          = out_st_q;

endmodule
